// ===== rtl/core/median_filter_3x3_defines.svh =====
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

`ifndef ASSERT_OFF
`define MF3_ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("median_filter_3x3 assertion failed");
`define MF3_ASSERT(lbl, prop) `MF3_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define MF3_ASSERT_CLK(lbl, clk_s, rstn_s, prop)
`define MF3_ASSERT(lbl, prop)
`endif

`endif

// ===== rtl/core/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, register indexes and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 3 * PIX_W;
  localparam int FW_W      = 12;
  localparam int FH_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  // top row in [23:16], middle [15:8], bottom [7:0]
  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    pix_t pixel_in;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic end_of_row;
    logic end_of_frame;
    logic last_in_run;
  } out_item_t;

  typedef struct packed {
    col_t w0;
    col_t w1;
    col_t w2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic r_ge1;
    logic last_row;
  } job_t;

  typedef struct packed {
    pix_t hi;
    pix_t md;
    pix_t lo;
  } csort_t;

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmax(a, b), c);
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return pmin(pmin(a, b), c);
  endfunction

  function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmin(pmax(a, b), c), pmin(a, b));
  endfunction

  function automatic csort_t col_sort(input col_t w);
    csort_t s;
    s.hi = max3(w[23:16], w[15:8], w[7:0]);
    s.md = mid3(w[23:16], w[15:8], w[7:0]);
    s.lo = min3(w[23:16], w[15:8], w[7:0]);
    return s;
  endfunction

  // window one row lower, bottom row replicated
  function automatic col_t lower_col(input col_t w);
    return {w[15:8], w[7:0], w[7:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mf3_stream_if.sv =====
// ----------------------------------------------------------------------------
// mf3_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mf3_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mf3_window.sv =====
// ----------------------------------------------------------------------------
// mf3_window
// Frame counters, line memory read-modify-write and the 3-column window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_window import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_W-1:0]      cfg_wr_data,
  mf3_stream_if.sink           in_ch,
  output logic                 job_valid,
  input  wire                  job_ready,
  output job_t                 job
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
  localparam int MW = 2 * PIX_W;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [AW-1:0]   col_cnt_r;
  logic [FH_W-1:0] row_cnt_r;

  logic [MW-1:0]   mem [MAX_WIDTH];
  logic [MW-1:0]   rd_data_r;
  logic            fwd_valid_r;
  logic [MW-1:0]   fwd_data_r;

  logic            s1_valid_r;
  pix_t            s1_pix_r;
  logic [AW-1:0]   s1_addr_r;
  logic            s1_c_ge1_r, s1_c_ge2_r, s1_last_col_r;
  logic            s1_r_ge1_r, s1_r_ge2_r, s1_last_row_r;

  col_t            w0_r, w1_r, w2_r;

  logic [EW-1:0]   fw_e, weff;
  logic [FH_W-1:0] heff;
  logic            last_col, last_row, fire, s1_adv;
  logic [MW-1:0]   mem_word, wr_word;
  pix_t            b_pix, a_pix;
  col_t            new_col;

  always_comb begin
    fw_e = EW'(frame_width_r);
    if (fw_e == '0) begin
      weff = EW'(1);
    end else if (fw_e > MAX_W_E) begin
      weff = MAX_W_E;
    end else begin
      weff = fw_e;
    end
    heff     = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    last_col = (EW'(col_cnt_r) + EW'(1)) >= weff;
    last_row = ({1'b0, row_cnt_r} + (FH_W + 1)'(1)) >= {1'b0, heff};
  end

  assign s1_adv       = s1_valid_r && job_ready;
  assign in_ch.ready  = !s1_valid_r || job_ready;
  assign fire         = in_ch.valid && in_ch.ready;

  assign mem_word = fwd_valid_r ? fwd_data_r : rd_data_r;
  assign b_pix    = s1_r_ge1_r ? mem_word[PIX_W-1:0] : s1_pix_r;
  assign a_pix    = s1_r_ge2_r ? mem_word[MW-1:PIX_W] : b_pix;
  assign wr_word  = {b_pix, s1_pix_r};
  assign new_col  = {a_pix, b_pix, s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mem[s1_addr_r] <= wr_word;
    end
    if (fire) begin
      rd_data_r <= mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_W'(640);
      frame_height_r <= FH_W'(480);
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      s1_valid_r     <= 1'b0;
      fwd_valid_r    <= 1'b0;
      w0_r           <= '0;
      w1_r           <= '0;
      w2_r           <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr_data[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        // write-back of the item ahead lands on the entry read now
        fwd_valid_r <= s1_adv && (s1_addr_r == col_cnt_r);
        fwd_data_r  <= wr_word;
        if (last_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= last_row ? '0 : row_cnt_r + FH_W'(1);
        end else begin
          col_cnt_r <= col_cnt_r + AW'(1);
        end
      end
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        w0_r <= w1_r;
        w1_r <= w2_r;
        w2_r <= new_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_pix_r      <= in_ch.data.pixel_in;
      s1_addr_r     <= col_cnt_r;
      s1_c_ge1_r    <= (col_cnt_r != '0);
      s1_c_ge2_r    <= (EW'(col_cnt_r) >= EW'(2));
      s1_last_col_r <= last_col;
      s1_r_ge1_r    <= (row_cnt_r != '0);
      s1_r_ge2_r    <= (row_cnt_r > FH_W'(1));
      s1_last_row_r <= last_row;
    end
  end

  assign job_valid     = s1_valid_r;
  assign job.w0        = w1_r;
  assign job.w1        = w2_r;
  assign job.w2        = new_col;
  assign job.c_ge1     = s1_c_ge1_r;
  assign job.c_ge2     = s1_c_ge2_r;
  assign job.last_col  = s1_last_col_r;
  assign job.r_ge1     = s1_r_ge1_r;
  assign job.last_row  = s1_last_row_r;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_emit.sv =====
// ----------------------------------------------------------------------------
// mf3_emit
// Result sequencer and two-stage median network with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_emit import mf3_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          job_valid,
  output logic         job_ready,
  input  job_t         job,
  mf3_stream_if.source out_ch
);

  job_t       job_r;
  logic [3:0] mask_r;
  logic       a_valid_r;
  csort_t     a_sort_r [3];
  logic       a_eor_r, a_eof_r, a_last_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic [3:0] new_mask, pick, mask_rest, mask_left;
  logic       a_ready, b_ready, issue, use_lower, right_edge;
  col_t       v0, v1, v2, left_c, mid_c, right_c;
  pix_t       lo, hi, md;

  // slot order: left result, right-edge result, then same on the lower window
  assign new_mask = {job.last_row & job.last_col, job.last_row & job.c_ge1,
                     job.r_ge1 & job.last_col, job.r_ge1 & job.c_ge1};

  assign b_ready   = !out_valid_r || out_ch.ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign issue     = (mask_r != '0) && a_ready;
  assign pick      = mask_r & (~mask_r + 4'd1);
  assign mask_rest = mask_r & ~pick;
  assign mask_left = issue ? mask_rest : mask_r;
  assign job_ready = (mask_left == '0);

  assign use_lower  = pick[2] | pick[3];
  assign right_edge = pick[1] | pick[3];

  always_comb begin
    v0 = use_lower ? lower_col(job_r.w0) : job_r.w0;
    v1 = use_lower ? lower_col(job_r.w1) : job_r.w1;
    v2 = use_lower ? lower_col(job_r.w2) : job_r.w2;
    if (right_edge) begin
      left_c = job_r.c_ge1 ? v1 : v2;
      mid_c  = v2;
    end else begin
      left_c = job_r.c_ge2 ? v0 : v1;
      mid_c  = v1;
    end
    right_c = v2;
  end

  always_comb begin
    lo = min3(a_sort_r[0].hi, a_sort_r[1].hi, a_sort_r[2].hi);
    hi = max3(a_sort_r[0].lo, a_sort_r[1].lo, a_sort_r[2].lo);
    md = mid3(a_sort_r[0].md, a_sort_r[1].md, a_sort_r[2].md);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= (job_valid && job_ready) ? new_mask : mask_left;
      if (a_ready) begin
        a_valid_r <= issue;
      end
      if (b_ready) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (a_ready) begin
      a_sort_r[0] <= col_sort(left_c);
      a_sort_r[1] <= col_sort(mid_c);
      a_sort_r[2] <= col_sort(right_c);
      a_eor_r     <= right_edge;
      a_eof_r     <= pick[3];
      a_last_r    <= (mask_rest == '0);
    end
    if (b_ready) begin
      out_item_r.pixel_out    <= mid3(lo, hi, md);
      out_item_r.end_of_row   <= a_eor_r;
      out_item_r.end_of_frame <= a_eof_r;
      out_item_r.last_in_run  <= a_last_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter with edge replication over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per transfer in raster order and returns the exact
// 3x3 median, one row and one column behind the input. A pixel is taken
// every clock while each pixel yields at most one result; a pixel that
// yields k results (end of row, last row: up to four) holds the input until
// all are issued, as the result sequencer feeds the median network one result
// per clock; output stalls hold both. The two previous rows sit in one
// MAX_WIDTH x 16 memory, read on input transfer and written back from the
// window stage; it needs no clearing pass after reset. Configuration must be
// written only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "median_filter_3x3_defines.svh"

module median_filter_3x3 import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_wr_data,
  mf3_stream_if.sink          in_ch,
  mf3_stream_if.source        out_ch
);

  logic job_valid;
  logic job_ready;
  job_t job;

  mf3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  mf3_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_ch    (out_ch)
  );

  `MF3_ASSERT(a_eof_closes_run, out_ch.valid && out_ch.data.end_of_frame |-> out_ch.data.end_of_row && out_ch.data.last_in_run)
  `MF3_ASSERT(a_job_holds, job_valid && !job_ready |=> job_valid)
  `MF3_ASSERT(a_accept_to_job, in_ch.valid && in_ch.ready |=> job_valid)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 median filter with edge replication.
// Pixels go in over a valid/ready channel, with random gaps on the input
// and random stalls on the output. A scoreboard keeps its own line buffers,
// window and counters, predicts every median with its row and frame
// markers, and checks each result in order. Frame sizes are changed while
// the filter is idle. Sizes include the tallest height, a width above the
// line depth, out-of-range values, and size changes in the middle of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mf3_pkg::*;

  localparam int LINE_DEPTH  = 2048;
  localparam int HOLD_OFF    = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int SMALL_ITEMS = 190;

  typedef enum {PIX_ANY, PIX_LOW, PIX_HIGH, PIX_RAIL} pix_mix_t;

  class median_scoreboard;
    pix_t            line_a [LINE_DEPTH];
    pix_t            line_b [LINE_DEPTH];
    col_t            cols [3];
    int unsigned     col_n;
    int unsigned     row_n;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    out_item_t       medians_due [$];
    int              errors;

    function new();
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      foreach (cols[i]) cols[i] = '0;
      col_n      = 0;
      row_n      = 0;
      width_reg  = 640;
      height_reg = 480;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = val[FW_W-1:0];
        REG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function pix_t hi_of(pix_t a, pix_t b, pix_t c);
      pix_t m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
    endfunction

    function pix_t lo_of(pix_t a, pix_t b, pix_t c);
      pix_t m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
    endfunction

    // middle of three: sum minus the two outer values
    function pix_t md_of(pix_t a, pix_t b, pix_t c);
      int s;
      s = int'(a) + int'(b) + int'(c) - int'(hi_of(a, b, c)) - int'(lo_of(a, b, c));
      return pix_t'(s);
    endfunction

    function pix_t col_hi(col_t w);
      return hi_of(w[23:16], w[15:8], w[7:0]);
    endfunction

    function pix_t col_lo(col_t w);
      return lo_of(w[23:16], w[15:8], w[7:0]);
    endfunction

    function pix_t col_md(col_t w);
      return md_of(w[23:16], w[15:8], w[7:0]);
    endfunction

    function pix_t median9(col_t l, col_t m, col_t r);
      return md_of(lo_of(col_hi(l), col_hi(m), col_hi(r)),
                   hi_of(col_lo(l), col_lo(m), col_lo(r)),
                   md_of(col_md(l), col_md(m), col_md(r)));
    endfunction

    // results of one output row; below shifts the window down with clamping
    function void emit_row(int unsigned c, bit last_col, bit below, bit frame_end);
      col_t      w0;
      col_t      w1;
      col_t      w2;
      out_item_t o;
      w0 = cols[0];
      w1 = cols[1];
      w2 = cols[2];
      if (below) begin
        w0 = {w0[15:0], w0[7:0]};
        w1 = {w1[15:0], w1[7:0]};
        w2 = {w2[15:0], w2[7:0]};
      end
      if (c >= 1) begin
        o.pixel_out    = median9((c >= 2) ? w0 : w1, w1, w2);
        o.end_of_row   = 1'b0;
        o.end_of_frame = 1'b0;
        o.last_in_run  = 1'b0;
        medians_due.push_back(o);
      end
      if (last_col) begin
        o.pixel_out    = median9((c >= 1) ? w1 : w2, w2, w2);
        o.end_of_row   = 1'b1;
        o.end_of_frame = frame_end;
        o.last_in_run  = 1'b0;
        medians_due.push_back(o);
      end
    endfunction

    function void note_pixel(pix_t p);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      int unsigned n_before;
      bit          last_col;
      bit          last_row;
      pix_t        a;
      pix_t        b;
      out_item_t   tail;
      w = width_reg;
      h = height_reg;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      if (h == 0) h = 1;
      c        = col_n;
      r        = row_n;
      idx      = c % LINE_DEPTH;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      n_before = medians_due.size();

      b = (r >= 1) ? line_a[idx] : p;
      a = (r >= 2) ? line_b[idx] : b;
      line_b[idx] = b;
      line_a[idx] = p;
      cols[0] = cols[1];
      cols[1] = cols[2];
      cols[2] = {a, b, p};

      if (r >= 1) emit_row(c, last_col, 1'b0, 1'b0);
      if (last_row) emit_row(c, last_col, 1'b1, last_col);
      if (medians_due.size() > n_before) begin
        tail = medians_due.pop_back();
        tail.last_in_run = 1'b1;
        medians_due.push_back(tail);
      end

      if (last_col) begin
        col_n = 0;
        row_n = last_row ? 0 : r + 1;
      end else begin
        col_n = c + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      string     bad;
      if (medians_due.size() == 0) begin
        report($sformatf("result pix=%0d with nothing expected", got.pixel_out));
      end else begin
        want = medians_due.pop_front();
        bad  = "";
        if (got.pixel_out !== want.pixel_out) bad = {bad, " pixel_out"};
        if (got.end_of_row !== want.end_of_row) bad = {bad, " end_of_row"};
        if (got.end_of_frame !== want.end_of_frame) bad = {bad, " end_of_frame"};
        if (got.last_in_run !== want.last_in_run) bad = {bad, " last_in_run"};
        if (bad != "")
          report($sformatf("%s: got %0d/%0b/%0b/%0b exp %0d/%0b/%0b/%0b", bad,
                           got.pixel_out, got.end_of_row, got.end_of_frame,
                           got.last_in_run, want.pixel_out, want.end_of_row,
                           want.end_of_frame, want.last_in_run));
      end
    endtask

    function int pending();
      return medians_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wr_data;
  bit                   tx_idle;
  bit                   rx_idle;

  mf3_stream_if #(.T(in_item_t))  pix_in_if ();
  mf3_stream_if #(.T(out_item_t)) med_out_if ();

  median_scoreboard sb = new();

  median_filter_3x3 #(.MAX_WIDTH(LINE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (pix_in_if),
    .out_ch     (med_out_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // transfers are sampled at the falling edge, ahead of the edge that takes them
  always @(negedge clk) begin
    if (rst_n) begin
      if (pix_in_if.valid && pix_in_if.ready) sb.note_pixel(pix_in_if.data.pixel_in);
      if (med_out_if.valid && med_out_if.ready) sb.check_result(med_out_if.data);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(negedge clk);
      if ((pix_in_if.valid && pix_in_if.ready) || (med_out_if.valid && med_out_if.ready))
        idle = 0;
      else
        idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    bit          taken;
    med_out_if.ready <= 1'b0;
    rx_idle = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        med_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      med_out_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = med_out_if.valid;
        @(posedge clk);
      end while (!taken);
      if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
    end
  end

  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    bit          taken;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.data  <= in_item_t'(p);
    do begin
      @(negedge clk);
      taken = pix_in_if.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_FRAME_WIDTH;
    cfg_wr_data <= w_val;
    @(posedge clk);
    cfg_index   <= REG_FRAME_HEIGHT;
    cfg_wr_data <= h_val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_reg(REG_FRAME_WIDTH, w_val);
    sb.write_reg(REG_FRAME_HEIGHT, h_val);
  endtask

  // stop sending, let every expected median arrive, then let the pipe settle
  task automatic drain();
    pix_in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  initial begin : stimulus
    pix_t        pat3 [9];
    int unsigned w;
    int unsigned h;
    int unsigned weff;
    int unsigned heff;
    int unsigned nframes;
    int unsigned sent;
    pix_mix_t    mix;
    pix_t        p;

    pat3 = '{8'h00, 8'hFF, 8'h10, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h00};
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_FRAME_WIDTH;
    cfg_wr_data     <= '0;
    pix_in_if.valid <= 1'b0;
    pix_in_if.data  <= '0;
    tx_idle = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-pixel frames
    set_frame(16'd1, 16'd1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    drain();

    // width 0 (upper bits dropped) and height 0 act as 1
    set_frame(16'hF000, 16'd0);
    send_pixel(8'h80);
    send_pixel(8'h01);
    drain();

    set_frame(16'd3, 16'd3);
    foreach (pat3[i]) send_pixel(pat3[i]);
    drain();

    // width shrinks in the middle of the second row
    set_frame(16'd4, 16'd3);
    repeat (5) send_pixel(pix_t'($urandom));
    drain();
    set_frame(16'd2, 16'd3);
    repeat (3) send_pixel(pix_t'($urandom));
    drain();

    // tallest frame, cut short by a height of 0 in its third row
    set_frame(16'd2, 16'hFFFF);
    repeat (4) send_pixel(pix_t'($urandom));
    drain();
    set_frame(16'd2, 16'd0);
    repeat (2) send_pixel(pix_t'($urandom));
    drain();

    // 4095 clamps to the line buffer depth; the row is then cut to seven
    set_frame(16'hFFFF, 16'd1);
    repeat (6) send_pixel(pix_t'($urandom));
    drain();
    set_frame(16'd7, 16'd1);
    send_pixel(pix_t'($urandom));
    drain();

    sent = 0;
    while (sent < SMALL_ITEMS) begin
      if ($urandom_range(0, 15) == 0) w = 0;
      else if ($urandom_range(0, 7) == 0) w = $urandom_range(9, 24);
      else w = $urandom_range(1, 8);
      h       = $urandom_range(0, (w > 8) ? 2 : 5);
      weff    = (w == 0) ? 1 : w;
      heff    = (h == 0) ? 1 : h;
      nframes = $urandom_range(1, 2);
      mix     = pix_mix_t'($urandom_range(0, 3));
      tx_idle = ($urandom_range(0, 3) != 0);
      set_frame({4'($urandom), 12'(w)}, 16'(h));
      repeat (weff * heff * nframes) begin
        case (mix)
          PIX_LOW:  p = pix_t'($urandom_range(0, 3));
          PIX_HIGH: p = pix_t'($urandom_range(252, 255));
          PIX_RAIL: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default:  p = pix_t'($urandom);
        endcase
        send_pixel(p);
        if ($urandom_range(0, 99) == 0) drain();
      end
      sent += weff * heff * nframes;
      drain();
    end

    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mf3_pkg.sv
rtl/core/mf3_stream_if.sv
rtl/core/mf3_window.sv
rtl/core/mf3_emit.sv
rtl/core/median_filter_3x3.sv
verif/tb.sv
